/* rtl/core/cmt_pkg.sv */
`default_nettype none

package cmt_pkg;

	localparam int MS_W    = 32;
	localparam int TICKS_W = 20;
	localparam int CNT_W   = 32;
	localparam int DATA_W  = 20;

	// Dividends for the chunk limit: full span of the narrow counter, top of the wide one.
	localparam logic [CNT_W-1:0] CNT16_SPAN = 32'd65536;
	localparam logic [CNT_W-1:0] CNT32_TOP  = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] MASK16     = 32'h0000_FFFF;
	localparam logic [CNT_W-1:0] MASK32     = 32'hFFFF_FFFF;

	localparam logic [TICKS_W-1:0] TICKS_RESET = 20'd1000;
	localparam logic [CNT_W-1:0]   CMP_RESET   = 32'd999;

	localparam logic REG_TICKS = 1'b0;
	localparam logic REG_WIDE  = 1'b1;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

/* rtl/core/cmt_div.sv */
`default_nettype none

module cmt_div import cmt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [CNT_W-1:0]   dividend,
	input  wire logic [TICKS_W-1:0] divisor,
	output div_sts_t                sts,
	output logic      [CNT_W-1:0]   quotient
);

	logic [CNT_W-1:0]     dq_q;
	logic [TICKS_W-1:0]   r_q;
	logic [TICKS_W-1:0]   d_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TICKS_W:0]   shifted;
	logic [TICKS_W+1:0] diff;
	logic               ge;

	// One restoring step per cycle: shift in the next dividend bit and try a subtract.
	assign shifted = {r_q, dq_q[CNT_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, d_q};
	assign ge      = ~diff[TICKS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[CNT_W-2:0], ge};
			r_q  <= ge ? diff[TICKS_W-1:0] : shifted[TICKS_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

/* rtl/core/cmt_mul.sv */
`default_nettype none

module cmt_mul import cmt_pkg::*; (
	input  wire logic               clk,
	input  wire logic [TICKS_W-1:0] a,
	input  wire logic [MS_W-1:0]    b,
	output logic      [CNT_W-1:0]   prod
);

	logic [TICKS_W+MS_W-1:0] full;
	logic [CNT_W-1:0]        prod_q;

	assign full = (TICKS_W + MS_W)'(a) * (TICKS_W + MS_W)'(b);

	// Only the low word matters: the compare value is taken modulo the counter width.
	always_ff @(posedge clk) begin
		prod_q <= full[CNT_W-1:0];
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* rtl/core/chunked_millisecond_oneshot_timer.sv */
// Tick items that schedule no new chunk, and zero-duration starts: result registered in the
// cycle after the transfer, one item per cycle while idle and no stalled result is held.
// A compare match that schedules another chunk: chunk select, multiply and compare update.
// A nonzero start: the 32-step shift-subtract divider forms the chunk limit, then those three.
// Reset: idle, no result pending, ticks_per_ms = 1000, 16-bit counter, compare = 999.
`default_nettype none

module chunked_millisecond_oneshot_timer import cmt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               mode,
	input  wire logic [MS_W-1:0]    duration_ms,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic                    expired,
	output logic                    chunk_done,
	output logic                    busy_res,
	output logic      [MS_W-1:0]    elapsed_ms,
	output logic      [MS_W-1:0]    remaining_ms,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [DATA_W-1:0]  cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SCHED = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DEC   = 3'd4;

	logic [2:0]         state_q;
	logic [TICKS_W-1:0] ticks_q;
	logic               wide_q;
	logic [CNT_W-1:0]   tick_q;
	logic [CNT_W-1:0]   cmp_q;
	logic [MS_W-1:0]    rem_q;
	logic [MS_W-1:0]    chunk_q;
	logic [MS_W-1:0]    elap_q;
	logic [MS_W-1:0]    limit_q;
	logic               running_q;
	logic               pend_chunk_q;

	logic               res_valid_q;
	logic               res_exp_q;
	logic               res_chunk_q;
	logic               res_busy_q;
	logic [MS_W-1:0]    res_elap_q;
	logic [MS_W-1:0]    res_rem_q;

	logic               accept;
	logic               res_take;
	logic [TICKS_W-1:0] t_eff;
	logic [CNT_W-1:0]   mask;
	logic               match;
	logic [MS_W-1:0]    elap_next;
	logic [MS_W-1:0]    rem_next;
	logic               div_start;
	div_sts_t           div_sts;
	logic [CNT_W-1:0]   div_q;
	logic [CNT_W-1:0]   prod;

	assign accept    = item_valid && !item_stall;
	assign res_take  = res_valid_q && !res_stall;
	assign item_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign cfg_ready = 1'b1;

	assign t_eff     = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
	assign mask      = wide_q ? MASK32 : MASK16;
	assign match     = (tick_q & mask) == (cmp_q & mask);
	assign elap_next = elap_q + chunk_q;
	assign rem_next  = rem_q - chunk_q;
	assign div_start = accept && (mode == MODE_START) && (duration_ms != '0);

	cmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wide_q ? CNT32_TOP : CNT16_SPAN),
		.divisor  (t_eff),
		.sts      (div_sts),
		.quotient (div_q)
	);

	cmt_mul u_mul (
		.clk  (clk),
		.a    (t_eff),
		.b    (chunk_q),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ticks_q      <= TICKS_RESET;
			wide_q       <= 1'b0;
			tick_q       <= '0;
			cmp_q        <= CMP_RESET;
			rem_q        <= '0;
			chunk_q      <= '0;
			elap_q       <= '0;
			limit_q      <= '0;
			running_q    <= 1'b0;
			pend_chunk_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICKS) begin
					ticks_q <= cfg_data;
				end else begin
					wide_q <= cfg_data[0];
				end
			end

			if (res_take) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_START) begin
							if (duration_ms == '0) begin
								res_valid_q <= 1'b1;
							end else begin
								elap_q       <= '0;
								rem_q        <= duration_ms;
								running_q    <= 1'b1;
								pend_chunk_q <= 1'b0;
								state_q      <= ST_DIV;
							end
						end else if (!match) begin
							tick_q      <= (tick_q + 1'b1) & mask;
							res_valid_q <= 1'b1;
						end else begin
							tick_q <= '0;
							if (running_q) begin
								elap_q <= elap_next;
								rem_q  <= rem_next;
								if (rem_next == '0) begin
									running_q   <= 1'b0;
									res_valid_q <= 1'b1;
								end else begin
									pend_chunk_q <= 1'b1;
									state_q      <= ST_SCHED;
								end
							end else begin
								res_valid_q <= 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						limit_q <= (div_q == '0) ? MS_W'(1) : div_q;
						state_q <= ST_SCHED;
					end
				end
				ST_SCHED: begin
					chunk_q <= (rem_q > limit_q) ? limit_q : rem_q;
					tick_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					cmp_q       <= (prod - 1'b1) & mask;
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; the fields of an immediate result are formed from the item and the timer state.
	always_ff @(posedge clk) begin
		if (state_q == ST_DEC) begin
			res_exp_q   <= 1'b0;
			res_chunk_q <= pend_chunk_q;
			res_busy_q  <= 1'b1;
			res_elap_q  <= elap_q;
			res_rem_q   <= rem_q;
		end else if (accept) begin
			res_elap_q <= elap_q;
			res_rem_q  <= rem_q;
			res_busy_q <= running_q;
			res_exp_q  <= 1'b0;
			res_chunk_q <= 1'b0;
			if (mode == MODE_START) begin
				res_exp_q <= (duration_ms == '0);
			end else if (match && running_q) begin
				res_chunk_q <= 1'b1;
				res_elap_q  <= elap_next;
				res_rem_q   <= rem_next;
				res_exp_q   <= (rem_next == '0);
				res_busy_q  <= (rem_next != '0);
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign expired      = res_exp_q;
	assign chunk_done   = res_chunk_q;
	assign busy_res     = res_busy_q;
	assign elapsed_ms   = res_elap_q;
	assign remaining_ms = res_rem_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> item_stall)
		else $error("item taken while the sequencer is busy");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the limit computation");

	a_idle_no_rem: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (rem_q == '0))
		else $error("remaining time left on a stopped timer");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC) |-> !res_valid_q)
		else $error("result register still occupied when a scheduled result is written");

endmodule

`default_nettype wire

/* dv/cmt_timer_checker.sv */
`timescale 1ns / 1ps

module cmt_timer_checker import cmt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire logic              mode,
	input  wire logic [MS_W-1:0]   duration_ms,
	input  wire logic              res_valid,
	input  wire logic              res_stall,
	input  wire logic              expired,
	input  wire logic              chunk_done,
	input  wire logic              busy_res,
	input  wire logic [MS_W-1:0]   elapsed_ms,
	input  wire logic [MS_W-1:0]   remaining_ms,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	output int                     fail_count,
	output int                     open_results
);

	typedef struct packed {
		logic            expired;
		logic            chunk_done;
		logic            busy;
		logic [MS_W-1:0] elapsed;
		logic [MS_W-1:0] remaining;
	} timer_res_t;

	// Shadow copy of the timer registers and state.
	logic [TICKS_W-1:0] ticks_cfg;
	logic               wide_cfg;
	logic [CNT_W-1:0]   tick_cnt;
	logic [CNT_W-1:0]   cmp_val;
	logic [CNT_W-1:0]   chunk_cap;
	logic [MS_W-1:0]    ms_left;
	logic [MS_W-1:0]    ms_done;
	logic [MS_W-1:0]    chunk_len;
	logic               timing;
	timer_res_t         due_q[$];
	int                 errs;

	function automatic logic [CNT_W-1:0] eff_ticks();
		return (ticks_cfg == '0) ? CNT_W'(1) : CNT_W'(ticks_cfg);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_mask();
		return wide_cfg ? MASK32 : MASK16;
	endfunction

	task automatic load_chunk();
		logic [63:0] prod;
		chunk_len = (ms_left > chunk_cap) ? chunk_cap : ms_left;
		tick_cnt = '0;
		prod = 64'(eff_ticks()) * 64'(chunk_len);
		cmp_val = (prod[CNT_W-1:0] - 1'b1) & cnt_mask();
	endtask

	task automatic step_timer(input logic m, input logic [MS_W-1:0] dur, output timer_res_t r);
		logic [CNT_W-1:0] lim;
		r = '0;
		if (m == MODE_START) begin
			if (dur == '0) begin
				r.expired = 1'b1;
			end else begin
				ms_done = '0;
				ms_left = dur;
				timing = 1'b1;
				lim = wide_cfg ? (CNT32_TOP / eff_ticks()) : (CNT16_SPAN / eff_ticks());
				chunk_cap = (lim == '0) ? CNT_W'(1) : lim;
				load_chunk();
			end
		end else if ((tick_cnt & cnt_mask()) == (cmp_val & cnt_mask())) begin
			tick_cnt = '0;
			if (timing) begin
				r.chunk_done = 1'b1;
				ms_done = ms_done + chunk_len;
				ms_left = ms_left - chunk_len;
				if (ms_left == '0) begin
					r.expired = 1'b1;
					timing = 1'b0;
				end else begin
					load_chunk();
				end
			end
		end else begin
			tick_cnt = (tick_cnt + 1'b1) & cnt_mask();
		end
		r.busy = timing;
		r.elapsed = ms_done;
		r.remaining = ms_left;
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_res_t want;
		timer_res_t got;
		if (!arst_n) begin
			ticks_cfg = TICKS_RESET;
			wide_cfg = 1'b0;
			tick_cnt = '0;
			cmp_val = CMP_RESET;
			chunk_cap = '0;
			ms_left = '0;
			ms_done = '0;
			chunk_len = '0;
			timing = 1'b0;
			due_q.delete();
			errs = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICKS)
					ticks_cfg = cfg_data[TICKS_W-1:0];
				else if (cfg_index == REG_WIDE)
					wide_cfg = cfg_data[0];
			end
			if (res_valid && !res_stall) begin
				got = {expired, chunk_done, busy_res, elapsed_ms, remaining_ms};
				if (due_q.size() == 0) begin
					if (errs < 10)
						$display("unexpected result transfer: elapsed %0d remaining %0d",
							elapsed_ms, remaining_ms);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						if (errs < 10)
							$display({"result mismatch (expected/actual): expired %0b/%0b ",
								"chunk_done %0b/%0b busy %0b/%0b elapsed %0d/%0d ",
								"remaining %0d/%0d"},
								want.expired, got.expired, want.chunk_done, got.chunk_done,
								want.busy, got.busy, want.elapsed, got.elapsed,
								want.remaining, got.remaining);
						errs++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				step_timer(mode, duration_ms, want);
				due_q.push_back(want);
			end
		end
		fail_count <= errs;
		open_results <= due_q.size();
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cmt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int N_PHASES       = 11;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic              mode;
	logic [MS_W-1:0]   duration_ms;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic              expired;
	logic              chunk_done;
	logic              busy_res;
	logic [MS_W-1:0]   elapsed_ms;
	logic [MS_W-1:0]   remaining_ms;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [DATA_W-1:0] cfg_data;

	int fail_count;
	int open_results;
	int quiet_cycles = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;

	// Rates per phase: tiny rates let chunks finish quickly, rates just above the narrow
	// span give a one-ms chunk limit with a short compare, the largest ones are extremes.
	int unsigned phase_ticks [N_PHASES] =
		'{1, 0, 65537, 2, 65538, 1, 3, 131073, 1000000, 20'hFFFFF, 1};
	bit          phase_wide  [N_PHASES] = '{0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0};
	int          phase_len   [N_PHASES] =
		'{120, 120, 120, 120, 120, 120, 120, 120, 40, 40, 120};

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	chunked_millisecond_oneshot_timer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.duration_ms  (duration_ms),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.expired      (expired),
		.chunk_done   (chunk_done),
		.busy_res     (busy_res),
		.elapsed_ms   (elapsed_ms),
		.remaining_ms (remaining_ms),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cmt_timer_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.duration_ms  (duration_ms),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.expired      (expired),
		.chunk_done   (chunk_done),
		.busy_res     (busy_res),
		.elapsed_ms   (elapsed_ms),
		.remaining_ms (remaining_ms),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always @(posedge clk) res_stall <= ($urandom_range(99) < rcv_stall_pct);

	// Ends the run if no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Valid is left high on return so that a following item needs no second assignment.
	task automatic push_item(input logic m, input logic [MS_W-1:0] dur);
		while ($urandom_range(99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		duration_ms <= dur;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timer_cfg(input logic [DATA_W-1:0] ticks, input logic wide);
		logic [DATA_W-2:0] junk;
		junk = (DATA_W-1)'($urandom());
		cfg_valid <= 1'b1;
		cfg_index <= REG_TICKS;
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		// Only bit 0 of the width register matters; the upper bits carry noise.
		cfg_index <= REG_WIDE;
		cfg_data <= {junk, wide};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [MS_W-1:0] pick_duration();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return '0;
		if (sel < 20)
			return $urandom();
		if (sel < 30)
			return $urandom_range(300, 1);
		return $urandom_range(8, 1);
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(11) == 0)
				push_item(MODE_START, pick_duration());
			else
				push_item(MODE_TICK, $urandom());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		mode <= MODE_TICK;
		duration_ms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TICKS;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rate of 1000 ticks per ms on the narrow counter.
		push_item(MODE_TICK, '0);
		push_item(MODE_START, '0);
		push_item(MODE_START, 32'd1);
		push_item(MODE_TICK, '1);
		// A zero start while running pulses expired and leaves the timer alone.
		push_item(MODE_START, '0);
		push_item(MODE_START, 32'hFFFF_FFFF);
		push_item(MODE_TICK, 32'h5555_5555);
		push_item(MODE_START, 32'h5555_5555);
		push_item(MODE_START, 32'hAAAA_AAAA);
		push_item(MODE_START, 32'd65);
		push_item(MODE_START, 32'd66);
		push_item(MODE_TICK, 32'hAAAA_AAAA);
		drain();

		// One tick per ms on the wide counter: short timers expire on the next match.
		set_timer_cfg(DATA_W'(1), 1'b1);
		push_item(MODE_START, 32'hFFFF_FFFF);
		push_item(MODE_START, 32'd1);
		push_item(MODE_TICK, '0);
		push_item(MODE_TICK, '0);
		push_item(MODE_START, 32'd2);
		push_item(MODE_TICK, '0);
		push_item(MODE_TICK, '0);
		push_item(MODE_TICK, '0);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			set_timer_cfg(DATA_W'(phase_ticks[p]), phase_wide[p]);
			case (p % 4)
				0: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct = 57;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 57;
				end
				default: begin
					snd_idle_pct = 13;
					rcv_stall_pct = 13;
				end
			endcase
			run_random(phase_len[p]);
			drain();
		end

		if (fail_count == 0 && open_results == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/cmt_pkg.sv
rtl/core/cmt_div.sv
rtl/core/cmt_mul.sv
rtl/core/chunked_millisecond_oneshot_timer.sv
dv/cmt_timer_checker.sv
dv/tb_top.sv
